// File: rtl/core/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared command codes, request types and step-count constants.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int unsigned StepW = 5;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_RACK  = 3'd4,
    OP_WACK  = 3'd5
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] wdata;
    logic [7:0] sampled;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam logic [StepW-1:0] LastStart = 5'd3;
  localparam logic [StepW-1:0] LastStop  = 5'd2;
  localparam logic [StepW-1:0] LastWrite = 5'd24;
  localparam logic [StepW-1:0] LastRead  = 5'd16;
  localparam logic [StepW-1:0] LastAck   = 5'd2;

endpackage

// File: rtl/core/i2cms_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master command channel
// Valid/ready channel that carries one bus command per request.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_data;
  logic [7:0] sda_sampled;

  modport source (output valid, operation, write_data, sda_sampled, input ready);
  modport sink (input valid, operation, write_data, sda_sampled, output ready);
endinterface

// File: rtl/core/i2cms_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master result channel
// Valid/ready channel that carries one line step per request.
// ----------------------------------------------------------------------------
interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] read_byte;
  logic       ack_seen;
  logic       last_step;

  modport source (output valid, scl_level, sda_level, read_byte, ack_seen, last_step,
                  input ready);
  modport sink (input valid, scl_level, sda_level, read_byte, ack_seen, last_step,
                output ready);
endinterface

// File: rtl/core/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer front end
// Accepts commands, drops unused operation codes and pushes the rest.
// ----------------------------------------------------------------------------
module i2cms_front
  import i2cms_pkg::*;
(
  i2cms_cmd_if.sink cmd_i,
  input  logic      full_i,
  output logic      push_o,
  output cmd_t      push_data_o
);

  logic op_ok;

  always_comb begin
    op_ok = cmd_i.operation inside {[OP_START:OP_WACK]};
  end

  assign cmd_i.ready          = ~full_i;
  assign push_o               = cmd_i.valid & ~full_i & op_ok;
  assign push_data_o.op       = op_e'(cmd_i.operation);
  assign push_data_o.wdata    = cmd_i.write_data;
  assign push_data_o.sampled  = cmd_i.sda_sampled;

endmodule

// File: rtl/core/i2cms_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master command queue
// Small register queue that decouples the front end from the sequencer.
// ----------------------------------------------------------------------------
module i2cms_fifo
  import i2cms_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cmd_t         push_data_i,
  input  logic         pop_i,
  output cmd_t         pop_data_o,
  output fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == CntFull);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i & ~status_o.full;
  assign do_pop         = pop_i & ~status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/i2cms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer back end
// Steps the bus lines of one command at a time into an output register and takes the next
// command as the last step goes out; steps wait while an unaccepted result is held.
module i2cms_back
  import i2cms_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fifo_status_t status_i,
  input  cmd_t         cmd_i,
  output logic         pop_o,
  i2cms_res_if.source  res_o
);

  logic             busy_q, busy_d;
  cmd_t             cmd_q, cmd_d;
  logic [StepW-1:0] step_q, step_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       shift_q, shift_d;
  logic             clock_q, clock_d;
  logic             data_q, data_d;
  logic             out_valid_q, out_valid_d;
  logic             out_scl_q, out_sda_q, out_ack_q, out_last_q;
  logic [7:0]       out_byte_q;
  logic             advance, is_last, is_scl, level;
  logic [StepW-1:0] last_idx;

  assign advance = busy_q & (~out_valid_q | res_o.ready);
  assign is_last = (step_q == last_idx);
  assign pop_o   = ~status_i.empty & (~busy_q | (advance & is_last));

  always_comb begin
    is_scl   = 1'b0;
    level    = 1'b1;
    last_idx = LastAck;
    case (cmd_q.op)
      OP_START: begin
        last_idx = LastStart;
        is_scl   = (step_q == 5'd1);
        level    = (step_q == 5'd0) | (step_q == 5'd1);
      end
      OP_STOP: begin
        last_idx = LastStop;
        is_scl   = (step_q == 5'd1);
        level    = (step_q != 5'd0);
      end
      OP_WRITE: begin
        last_idx = LastWrite;
        if (step_q == LastWrite) begin
          is_scl = 1'b1;
          level  = 1'b0;
        end else begin
          case (phase_q)
            2'd0: begin
              is_scl = 1'b1;
              level  = 1'b0;
            end
            2'd1: begin
              is_scl = 1'b0;
              level  = shift_q[7];
            end
            default: begin
              is_scl = 1'b1;
              level  = 1'b1;
            end
          endcase
        end
      end
      OP_READ: begin
        last_idx = LastRead;
        is_scl   = (step_q != 5'd0);
        level    = (step_q == 5'd0) | step_q[0];
      end
      OP_RACK: begin
        is_scl = (step_q != 5'd0);
        level  = (step_q != 5'd2);
      end
      OP_WACK: begin
        is_scl = (step_q != 5'd0);
        level  = (step_q == 5'd0) ? cmd_q.wdata[0] : (step_q == 5'd1);
      end
      default: begin
        is_scl = 1'b0;
        level  = data_q;
      end
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    cmd_d       = cmd_q;
    step_d      = step_q;
    phase_d     = phase_q;
    shift_d     = shift_q;
    clock_d     = clock_q;
    data_d      = data_q;
    out_valid_d = out_valid_q & ~res_o.ready;
    if (advance) begin
      out_valid_d = 1'b1;
      if (is_scl) begin
        clock_d = level;
      end else begin
        data_d = level;
      end
      step_d  = step_q + 1'b1;
      phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 1'b1;
      if (cmd_q.op == OP_WRITE && phase_q == 2'd1) begin
        shift_d = {shift_q[6:0], 1'b0};
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d  = 1'b1;
      cmd_d   = cmd_i;
      step_d  = '0;
      phase_d = '0;
      shift_d = cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      clock_q     <= 1'b1;
      data_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      clock_q     <= clock_d;
      data_q      <= data_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    step_q  <= step_d;
    phase_q <= phase_d;
    shift_q <= shift_d;
    if (advance) begin
      out_scl_q  <= clock_d;
      out_sda_q  <= data_d;
      out_last_q <= is_last;
      out_byte_q <= (cmd_q.op == OP_READ && is_last) ? cmd_q.sampled : 8'h00;
      out_ack_q  <= (cmd_q.op == OP_RACK) & is_last & cmd_q.sampled[7];
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = out_scl_q;
  assign res_o.sda_level = out_sda_q;
  assign res_o.read_byte = out_byte_q;
  assign res_o.ack_seen  = out_ack_q;
  assign res_o.last_step = out_last_q;

endmodule

// File: rtl/core/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Throughput: one line step per cycle from the sequencer while the result
// channel takes each step; a command has 3 to 25 steps (write byte 25).
// Reset returns both bus lines to released and empties the command queue.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
#(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cms_cmd_if.sink   cmd_i,
  i2cms_res_if.source res_o
);

  logic         push, pop;
  cmd_t         push_data, pop_data;
  fifo_status_t fifo_status;

  i2cms_front u_front (
    .cmd_i       (cmd_i),
    .full_i      (fifo_status.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  i2cms_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  i2cms_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (fifo_status),
    .cmd_i    (pop_data),
    .pop_o    (pop),
    .res_o    (res_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_status.full && fifo_status.empty))
    else $error("Command queue reports full and empty at once.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_status.full)
    else $error("Command pushed into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.read_byte != 8'h00 || res_o.ack_seen) |-> res_o.last_step)
    else $error("Read data shown on a step that is not the last one.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("Command popped from an empty queue.");

endmodule
